>>> sv/rst_pkg.sv
package rst_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int RESULT_CAP      = 64;
	localparam int RES_W           = 7;
	localparam int ADDR_W          = 3;
	localparam logic [15:0] WINDOW_RESET = 16'd50;

	localparam logic [2:0] OP_SEND    = 3'd0;
	localparam logic [2:0] OP_ACK     = 3'd1;
	localparam logic [2:0] OP_REPLAY  = 3'd2;
	localparam logic [2:0] OP_DATA    = 3'd3;
	localparam logic [2:0] OP_FRAG    = 3'd4;
	localparam logic [2:0] OP_OPEN    = 3'd5;
	localparam logic [2:0] OP_CLOSE   = 3'd6;

	localparam logic [3:0] KIND_ASSIGNED   = 4'd0;
	localparam logic [3:0] KIND_ACK        = 4'd1;
	localparam logic [3:0] KIND_OOO        = 4'd2;
	localparam logic [3:0] KIND_DELIVER    = 4'd3;
	localparam logic [3:0] KIND_FRAG_DONE  = 4'd4;
	localparam logic [3:0] KIND_CALLBACK   = 4'd5;
	localparam logic [3:0] KIND_RESEND     = 4'd6;
	localparam logic [3:0] KIND_DISCONNECT = 4'd7;
	localparam logic [3:0] KIND_QUEUE_FULL = 4'd8;

	// request from the sequencer to the result stage
	typedef struct packed {
		logic        emit;
		logic        finish;
		logic [3:0]  kind;
		logic [15:0] seq;
		logic [15:0] len;
	} rst_emit_t;

	function automatic rst_emit_t make_emit(input logic [3:0] kind, input logic [15:0] seq,
			input logic [15:0] len);
		rst_emit_t r;
		r        = '0;
		r.emit   = 1'b1;
		r.kind   = kind;
		r.seq    = seq;
		r.len    = len;
		return r;
	endfunction

endpackage

>>> sv/rst_result_stage.sv
module rst_result_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  rst_pkg::rst_emit_t req,
	output logic              hold,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,  // result_sequence[15:0], reassembled_length[31:16]
	output logic [3:0]        m_tuser,  // kind[3:0]
	output logic              m_tlast
);

	logic        pend_valid_q;
	logic [3:0]  pend_kind_q;
	logic [15:0] pend_seq_q;
	logic [15:0] pend_len_q;
	logic        out_valid_q;
	logic [3:0]  out_kind_q;
	logic [15:0] out_seq_q;
	logic [15:0] out_len_q;
	logic        out_last_q;
	logic        move;

	// the held result goes out once we know whether another one follows
	assign move = (req.emit || req.finish) && pend_valid_q;
	assign hold = pend_valid_q && out_valid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end
			if (req.emit) begin
				pend_valid_q <= 1'b1;
			end else if (req.finish) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_kind_q <= pend_kind_q;
			out_seq_q  <= pend_seq_q;
			out_len_q  <= pend_len_q;
			out_last_q <= req.finish;
		end
		if (req.emit) begin
			pend_kind_q <= req.kind;
			pend_seq_q  <= req.seq;
			pend_len_q  <= req.len;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_len_q, out_seq_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	a_move_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		move |-> (!out_valid_q || m_tready))
		else $error("held result moved into a full output register");

	a_emit_finish_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.emit && req.finish))
		else $error("emit and finish requested together");

	a_finish_drains: assert property (@(posedge clk) disable iff (!arst_n)
		req.finish |=> !pend_valid_q)
		else $error("held result remains after finish");

endmodule

>>> sv/reliable_sequence_tracker_unit.sv
// Sequence engine of a reliable datagram session. Each input transaction carries one
// operation and is handled alone: s_tready is high only while no operation is in work.
// Send, open, close, unused operations and mismatched data or fragments go from
// S_EXEC to S_FLUSH and back to S_IDLE; a matched data or fragment item passes
// S_DELIVER on the way. Ack and out-of-order replay walk the pending queue through its
// single registered read port at one entry per cycle unless the output stalls, in
// S_ACK or S_RPL (up to the queue depth, at most 64 results). Results leave through an
// output register, each one held back until the next is known so that m_tlast marks the
// final result of the operation. The pending queue needs no clearing after reset.
module reliable_sequence_tracker_unit #(
	parameter int QUEUE_DEPTH = rst_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// sequence_req[15:0], has_callback[16], fragment_total[32:17], payload_length[48:33]
	input  logic [55:0]              s_tdata,
	input  logic [2:0]               s_tuser,  // operation[2:0]
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [31:0]              m_tdata,  // result_sequence[15:0], reassembled_length[31:16]
	output logic [3:0]               m_tuser,  // kind[3:0]
	output logic                     m_tlast,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [rst_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [rst_pkg::RES_W-1:0] CAP_C = rst_pkg::RES_W'(rst_pkg::RESULT_CAP);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_EXEC    = 7'b0000010,
		S_DELIVER = 7'b0000100,
		S_ACK     = 7'b0001000,
		S_RPL     = 7'b0010000,
		S_FLUSH   = 7'b0100000,
		S_SPARE   = 7'b1000000
	} state_t;

	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	state_t                    state_q, state_d;
	logic [2:0]                op_q;
	logic [15:0]               seq_q;
	logic                      cb_q;
	logic [15:0]               ftot_q;
	logic [15:0]               plen_q;
	logic [15:0]               window_q;
	logic [15:0]               nsend_q, nsend_d;
	logic [15:0]               nexp_q, nexp_d;
	logic                      conn_q, conn_d;
	logic [15:0]               frag_total_q, frag_total_d;
	logic [16:0]               frag_acc_q, frag_acc_d;
	logic [PTR_W-1:0]          head_q, head_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [PTR_W-1:0]          idx_q, idx_d;
	logic [rst_pkg::RES_W-1:0] n_q, n_d;

	logic [16:0]               mem_q [QUEUE_DEPTH];
	logic [16:0]               rd_data_q;
	logic [PTR_W-1:0]          rd_addr, rd_addr_go, cur_addr, wr_addr;
	logic                      mem_we;

	rst_pkg::rst_emit_t        req, req_gated;
	logic                      hold, stall, accept, far_ahead, continuing, frag_done;
	logic [15:0]               entry_seq, frag_tot;
	logic                      entry_cb;
	logic [17:0]               acc_sum;
	logic [16:0]               acc_sat;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign entry_seq = rd_data_q[15:0];
	assign entry_cb  = rd_data_q[16];
	assign wr_addr   = wrap_add(head_q, count_q);
	assign cur_addr  = (state_q == S_RPL) ? wrap_add(head_q, CNT_W'(idx_q)) : head_q;

	// bound is taken in 17 bits and does not wrap
	assign far_ahead = ({1'b0, seq_q} > ({1'b0, nexp_q} + {1'b0, window_q}))
		&& (nexp_q > window_q);

	assign continuing = (frag_total_q != 16'd0);
	assign frag_tot   = continuing ? frag_total_q : ftot_q;
	assign acc_sum    = {1'b0, frag_acc_q} + 18'(plen_q);
	assign acc_sat    = acc_sum[17] ? 17'h1FFFF : acc_sum[16:0];
	assign frag_done  = continuing && (acc_sat == {1'b0, frag_total_q});

	always_comb begin
		state_d      = state_q;
		nsend_d      = nsend_q;
		nexp_d       = nexp_q;
		conn_d       = conn_q;
		frag_total_d = frag_total_q;
		frag_acc_d   = frag_acc_q;
		head_d       = head_q;
		count_d      = count_q;
		idx_d        = idx_q;
		n_d          = n_q;
		req          = '0;
		mem_we       = 1'b0;
		rd_addr_go   = cur_addr;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_EXEC;
					n_d     = '0;
					idx_d   = '0;
				end
			end
			S_EXEC: begin
				state_d = S_FLUSH;
				case (op_q)
					rst_pkg::OP_SEND: begin
						if (count_q == DEPTH_C) begin
							req = rst_pkg::make_emit(rst_pkg::KIND_QUEUE_FULL, nsend_q, 16'd0);
						end else begin
							mem_we  = 1'b1;
							count_d = count_q + CNT_W'(1);
							nsend_d = nsend_q + 16'd1;
							req = rst_pkg::make_emit(rst_pkg::KIND_ASSIGNED, nsend_q, 16'd0);
						end
					end
					rst_pkg::OP_ACK: begin
						if (count_q != '0) begin
							state_d = S_ACK;
						end
					end
					rst_pkg::OP_REPLAY: begin
						if (count_q != '0) begin
							state_d = S_RPL;
						end
					end
					rst_pkg::OP_DATA, rst_pkg::OP_FRAG: begin
						if (seq_q == nexp_q) begin
							req     = rst_pkg::make_emit(rst_pkg::KIND_ACK, seq_q, 16'd0);
							nexp_d  = seq_q + 16'd1;
							state_d = S_DELIVER;
						end else if (far_ahead) begin
							if (conn_q) begin
								conn_d = 1'b0;
								req = rst_pkg::make_emit(rst_pkg::KIND_DISCONNECT, seq_q, 16'd0);
							end
						end else begin
							req = rst_pkg::make_emit(rst_pkg::KIND_OOO, nexp_q - 16'd1, 16'd0);
						end
					end
					rst_pkg::OP_OPEN: begin
						conn_d = 1'b1;
					end
					rst_pkg::OP_CLOSE: begin
						if (conn_q) begin
							conn_d = 1'b0;
							req = rst_pkg::make_emit(rst_pkg::KIND_DISCONNECT, 16'd0, 16'd0);
						end
					end
					default: begin
					end
				endcase
			end
			S_DELIVER: begin
				state_d = S_FLUSH;
				if (op_q == rst_pkg::OP_DATA) begin
					req = rst_pkg::make_emit(rst_pkg::KIND_DELIVER, seq_q, 16'd0);
				end else if (frag_done) begin
					req = rst_pkg::make_emit(rst_pkg::KIND_FRAG_DONE, seq_q, frag_total_q);
					frag_total_d = 16'd0;
					frag_acc_d   = '0;
				end else begin
					frag_total_d = frag_tot;
					frag_acc_d   = acc_sat;
				end
			end
			S_ACK: begin
				if (entry_seq <= seq_q) begin
					if (entry_cb && (n_q >= CAP_C)) begin
						// result cap reached: this entry and the rest stay queued
						state_d = S_FLUSH;
					end else begin
						if (entry_cb) begin
							req = rst_pkg::make_emit(rst_pkg::KIND_CALLBACK, entry_seq, 16'd0);
							n_d = n_q + rst_pkg::RES_W'(1);
						end
						head_d     = wrap_add(head_q, CNT_W'(1));
						count_d    = count_q - CNT_W'(1);
						rd_addr_go = head_d;
						if (count_q == CNT_W'(1)) begin
							state_d = S_FLUSH;
						end
					end
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_RPL: begin
				req = rst_pkg::make_emit(rst_pkg::KIND_RESEND, entry_seq, 16'd0);
				n_d = n_q + rst_pkg::RES_W'(1);
				if ((entry_seq == seq_q) || (CNT_W'(idx_q) + CNT_W'(1) == count_q)
						|| (n_q == CAP_C - rst_pkg::RES_W'(1))) begin
					state_d = S_FLUSH;
				end else begin
					idx_d      = idx_q + PTR_W'(1);
					rd_addr_go = wrap_add(head_q, CNT_W'(idx_d));
				end
			end
			S_FLUSH: begin
				req.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// a result cannot advance while the output register is still full
	assign stall     = (req.emit || req.finish) && hold;
	assign req_gated = stall ? '0 : req;
	assign rd_addr   = stall ? cur_addr : rd_addr_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			nsend_q      <= 16'd0;
			nexp_q       <= 16'd0;
			conn_q       <= 1'b0;
			frag_total_q <= 16'd0;
			frag_acc_q   <= '0;
			head_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			window_q     <= rst_pkg::WINDOW_RESET;
		end else begin
			if (!stall) begin
				state_q      <= state_d;
				nsend_q      <= nsend_d;
				nexp_q       <= nexp_d;
				conn_q       <= conn_d;
				frag_total_q <= frag_total_d;
				frag_acc_q   <= frag_acc_d;
				head_q       <= head_d;
				count_q      <= count_d;
				idx_q        <= idx_d;
				n_q          <= n_d;
			end
			if (psel && penable && pwrite && pready && (paddr[rst_pkg::ADDR_W-1:2] == '0)) begin
				window_q <= pwdata[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			seq_q  <= s_tdata[15:0];
			cb_q   <= s_tdata[16];
			ftot_q <= s_tdata[32:17];
			plen_q <= s_tdata[48:33];
		end
	end

	// pending queue: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we && !stall) begin
			mem_q[wr_addr] <= {cb_q, nsend_q};
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign pready = 1'b1;
	assign prdata = (paddr[rst_pkg::ADDR_W-1:2] == '0) ? {16'd0, window_q} : 32'd0;

	rst_result_stage u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_gated),
		.hold     (hold),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count beyond depth");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted transaction not taken into work");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_ACK) || (state_q == S_RPL)) |-> (count_q != '0))
		else $error("queue walk on an empty queue");

endmodule

>>> dv/tb_reliable_sequence_tracker_unit.sv
module tb_reliable_sequence_tracker_unit;

	localparam int          RING_DEPTH  = 64;
	localparam int          SETTLE      = 100;
	localparam int          STALL_LIMIT = 4000;
	localparam logic [2:0]  OP_UNUSED   = 3'd7;
	localparam logic [rst_pkg::ADDR_W-1:0] WINDOW_ADDR = '0;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] seq;
		logic [15:0] len;
		logic        last;
	} tracker_result_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [rst_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	reliable_sequence_tracker_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the session state
	logic [15:0] window_q;
	logic [15:0] next_send;
	logic [15:0] next_expected;
	logic [15:0] last_acked;
	bit          connected;
	logic [15:0] frag_total;
	logic [16:0] frag_acc;
	logic [15:0] ring_seq [RING_DEPTH];
	bit          ring_cb  [RING_DEPTH];
	int          ring_head;
	int          ring_count;

	tracker_result_t op_results[$];
	tracker_result_t awaited_results[$];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int error_count = 0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (error_count < 50)
			$display("mismatch: %s", what);
		error_count++;
	endtask

	function automatic void reset_shadow();
		window_q      = rst_pkg::WINDOW_RESET;
		next_send     = '0;
		next_expected = '0;
		last_acked    = '0;
		connected     = 1'b0;
		frag_total    = '0;
		frag_acc      = '0;
		ring_head     = 0;
		ring_count    = 0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			ring_seq[i] = '0;
			ring_cb[i]  = 1'b0;
		end
	endfunction

	function automatic void post_result(input logic [3:0] kind, input logic [15:0] seq,
			input logic [15:0] len);
		tracker_result_t r;
		r.kind = kind;
		r.seq  = seq;
		r.len  = len;
		r.last = 1'b0;
		if (op_results.size() < rst_pkg::RESULT_CAP)
			op_results.push_back(r);
	endfunction

	// returns 1 when the received sequence is the expected one
	function automatic bit match_sequence(input logic [15:0] seq);
		logic [16:0] bound;
		bound = {1'b0, next_expected} + {1'b0, window_q};
		if (seq == next_expected) begin
			post_result(rst_pkg::KIND_ACK, seq, '0);
			next_expected = seq + 16'd1;
			return 1'b1;
		end
		if (({1'b0, seq} > bound) && (next_expected > window_q)) begin
			if (connected) begin
				connected = 1'b0;
				post_result(rst_pkg::KIND_DISCONNECT, seq, '0);
			end
		end else begin
			post_result(rst_pkg::KIND_OOO, next_expected - 16'd1, '0);
		end
		return 1'b0;
	endfunction

	function automatic void track_operation(input logic [2:0] op, input logic [15:0] seq,
			input bit cb, input logic [15:0] ftot, input logic [15:0] plen);
		int          slot;
		bit          continuing;
		logic [17:0] sum;
		tracker_result_t r;
		op_results.delete();
		case (op)
			rst_pkg::OP_SEND: begin
				if (ring_count >= RING_DEPTH) begin
					post_result(rst_pkg::KIND_QUEUE_FULL, next_send, '0);
				end else begin
					slot = (ring_head + ring_count) % RING_DEPTH;
					ring_seq[slot] = next_send;
					ring_cb[slot]  = cb;
					ring_count++;
					post_result(rst_pkg::KIND_ASSIGNED, next_send, '0);
					next_send = next_send + 16'd1;
				end
			end
			rst_pkg::OP_ACK: begin
				while (ring_count > 0 && ring_seq[ring_head] <= seq) begin
					if (ring_cb[ring_head]) begin
						if (op_results.size() >= rst_pkg::RESULT_CAP)
							break;
						post_result(rst_pkg::KIND_CALLBACK, ring_seq[ring_head], '0);
					end
					ring_head = (ring_head + 1) % RING_DEPTH;
					ring_count--;
				end
				last_acked = seq;
			end
			rst_pkg::OP_REPLAY: begin
				for (int i = 0; i < ring_count && op_results.size() < rst_pkg::RESULT_CAP;
						i++) begin
					slot = (ring_head + i) % RING_DEPTH;
					post_result(rst_pkg::KIND_RESEND, ring_seq[slot], '0);
					if (ring_seq[slot] == seq)
						break;
				end
			end
			rst_pkg::OP_DATA: begin
				if (match_sequence(seq))
					post_result(rst_pkg::KIND_DELIVER, seq, '0);
			end
			rst_pkg::OP_FRAG: begin
				if (match_sequence(seq)) begin
					continuing = (frag_total != 0);
					if (!continuing)
						frag_total = ftot;
					sum = {1'b0, frag_acc} + {2'b0, plen};
					frag_acc = (sum > 18'h1FFFF) ? 17'h1FFFF : sum[16:0];
					if (continuing && frag_acc == {1'b0, frag_total}) begin
						post_result(rst_pkg::KIND_FRAG_DONE, seq, frag_total);
						frag_total = '0;
						frag_acc   = '0;
					end
				end
			end
			rst_pkg::OP_OPEN: connected = 1'b1;
			rst_pkg::OP_CLOSE: begin
				if (connected) begin
					connected = 1'b0;
					post_result(rst_pkg::KIND_DISCONNECT, '0, '0);
				end
			end
			default: ;
		endcase
		if (op_results.size() > 0) begin
			r = op_results.pop_back();
			r.last = 1'b1;
			op_results.push_back(r);
		end
		foreach (op_results[i])
			awaited_results.push_back(op_results[i]);
	endfunction

	task automatic send_item(input logic [2:0] op, input logic [15:0] seq, input bit cb,
			input logic [15:0] ftot, input logic [15:0] plen);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'b0, plen, ftot, cb, seq};
		do @(posedge clk); while (!s_tready);
		track_operation(op, seq, cb, ftot, plen);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	task automatic write_window(input logic [15:0] value);
		hold_until_drained();
		// an ack that pops only silent entries may still be walking the queue
		repeat (SETTLE) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= WINDOW_ADDR;
		pwdata  <= {16'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		window_q = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// result checker and receiver side stall
	always @(posedge clk) begin
		tracker_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d seq %h len %h last %b",
					m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast));
			end else begin
				want = awaited_results[0];
				awaited_results.delete(0);
				if (m_tuser !== want.kind || m_tdata[15:0] !== want.seq ||
						m_tdata[31:16] !== want.len || m_tlast !== want.last)
					report_mismatch($sformatf(
						"kind %0d/%0d seq %h/%h len %h/%h last %b/%b (got/exp)",
						m_tuser, want.kind, m_tdata[15:0], want.seq,
						m_tdata[31:16], want.len, m_tlast, want.last));
			end
		end
		m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", awaited_results.size());
			$display("tb_reliable_sequence_tracker_unit: FAIL");
			$finish;
		end
	end

	task automatic test_directed_ops();
		send_item(rst_pkg::OP_CLOSE, 16'h0000, 1'b0, 16'h0000, 16'h0000);  // not connected
		send_item(rst_pkg::OP_ACK, 16'h0000, 1'b0, 16'h0000, 16'h0000);    // empty queue
		send_item(rst_pkg::OP_DATA, 16'h0007, 1'b0, 16'h0000, 16'h0000);   // out of order wraps
		send_item(rst_pkg::OP_OPEN, 16'h0000, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_DATA, 16'h0000, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_SEND, 16'h0000, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_SEND, 16'h0000, 1'b1, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_SEND, 16'h0000, 1'b1, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_REPLAY, 16'h0001, 1'b0, 16'h0000, 16'h0000);
		// no match, whole queue
		send_item(rst_pkg::OP_REPLAY, 16'hFFFF, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_ACK, 16'h0001, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_FRAG, 16'h0001, 1'b0, 16'd10, 16'd4);          // run starts
		send_item(rst_pkg::OP_FRAG, 16'h0002, 1'b0, 16'hFFFF, 16'd6);        // run completes
		send_item(rst_pkg::OP_FRAG, 16'h0003, 1'b0, 16'd5, 16'd3);
		send_item(rst_pkg::OP_FRAG, 16'h0004, 1'b0, 16'h0000, 16'hFFFF);     // overshoot stays open
		send_item(rst_pkg::OP_FRAG, 16'h0009, 1'b0, 16'h0000, 16'h0000);
		send_item(OP_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
		send_item(rst_pkg::OP_CLOSE, 16'h0000, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_ACK, 16'hFFFF, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_DATA, 16'h0005, 1'b1, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_window_extremes();
		write_window(16'h0000);
		send_item(rst_pkg::OP_OPEN, 16'h0000, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_DATA, 16'hFFFF, 1'b0, 16'h0000, 16'h0000);    // too far ahead
		send_item(rst_pkg::OP_DATA, 16'hFFFF, 1'b0, 16'h0000, 16'h0000);    // already closed
		send_item(rst_pkg::OP_DATA, next_expected + 16'd1, 1'b0, 16'h0000, 16'h0000);
		write_window(16'hFFFF);
		send_item(rst_pkg::OP_OPEN, 16'h0000, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_DATA, 16'hFFFF, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_DATA, next_expected, 1'b0, 16'h0000, 16'h0000);
	endtask

	task automatic test_queue_full();
		write_window(rst_pkg::WINDOW_RESET);
		for (int i = 0; i <= RING_DEPTH; i++)
			send_item(rst_pkg::OP_SEND, 16'h0000, 1'b1, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_REPLAY, 16'hFFFF, 1'b0, 16'h0000, 16'h0000);
		send_item(rst_pkg::OP_ACK, 16'hFFFF, 1'b0, 16'h0000, 16'h0000);
	endtask

	function automatic logic [15:0] queued_or_random();
		if (ring_count > 0 && $urandom_range(0, 3) != 0)
			return ring_seq[(ring_head + $urandom_range(0, ring_count - 1)) % RING_DEPTH];
		return 16'($urandom);
	endfunction

	task automatic random_item();
		logic [2:0]  op;
		logic [15:0] seq;
		logic [15:0] ftot;
		logic [15:0] plen;
		bit          cb;
		int          pick;
		pick = $urandom_range(0, 99);
		seq  = 16'($urandom);
		ftot = 16'($urandom);
		plen = 16'($urandom);
		cb   = 1'($urandom);
		if (pick < 22) begin
			op = rst_pkg::OP_SEND;
		end else if (pick < 34) begin
			op  = rst_pkg::OP_ACK;
			seq = queued_or_random();
		end else if (pick < 42) begin
			op  = rst_pkg::OP_REPLAY;
			seq = queued_or_random();
		end else if (pick < 80) begin
			op = (pick < 60) ? rst_pkg::OP_DATA : rst_pkg::OP_FRAG;
			case ($urandom_range(0, 7))
				0: seq = next_expected + window_q + 16'($urandom_range(1, 20));
				1: seq = 16'($urandom);
				default: seq = next_expected;
			endcase
			if ($urandom_range(0, 7) != 0) begin
				ftot = 16'($urandom_range(1, 200));
				if (frag_total != 0 && frag_acc < {1'b0, frag_total} && $urandom_range(0, 1))
					plen = frag_total - frag_acc[15:0];
				else
					plen = 16'($urandom_range(0, 100));
			end
		end else if (pick < 88) begin
			op = rst_pkg::OP_OPEN;
		end else if (pick < 94) begin
			op = rst_pkg::OP_CLOSE;
		end else begin
			op = OP_UNUSED;
		end
		send_item(op, seq, cb, ftot, plen);
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input logic [15:0] window,
			input int count, input bit pause_midway);
		write_window(window);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				hold_until_drained();
			random_item();
		end
	endtask

	task automatic test_random_traffic();
		run_phase(0, 0, rst_pkg::WINDOW_RESET, 95, 1'b0);
		run_phase(59, 0, 16'($urandom_range(0, 30)), 95, 1'b1);
		run_phase(0, 59, 16'hFFFF, 95, 1'b0);
		run_phase(14, 14, 16'($urandom_range(0, 10)), 95, 1'b0);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
	endtask

	initial begin
		reset_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_window_extremes();
		test_queue_full();
		test_random_traffic();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
		if (error_count == 0) begin
			$display("tb_reliable_sequence_tracker_unit: PASS");
		end else begin
			$display("tb_reliable_sequence_tracker_unit: FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
sv/rst_pkg.sv
sv/rst_result_stage.sv
sv/reliable_sequence_tracker_unit.sv
dv/tb_reliable_sequence_tracker_unit.sv
